// File: src/tce_pkg.sv
`default_nettype none
package tce_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 256;
	localparam int ROW_W = 6;
	localparam int COL_W = 8;

	// result kinds
	localparam logic [2:0] K_WRAP   = 3'd0;
	localparam logic [2:0] K_SCRUP  = 3'd1;
	localparam logic [2:0] K_SCRDN  = 3'd2;
	localparam logic [2:0] K_INSERT = 3'd3;
	localparam logic [2:0] K_WRITE  = 3'd4;
	localparam logic [2:0] K_CONT   = 3'd5;
	localparam logic [2:0] K_BELL   = 3'd6;
	localparam logic [2:0] K_STATUS = 3'd7;

	// control bytes
	localparam logic [20:0] C_BEL = 21'h07;
	localparam logic [20:0] C_BS  = 21'h08;
	localparam logic [20:0] C_HT  = 21'h09;
	localparam logic [20:0] C_LF  = 21'h0a;
	localparam logic [20:0] C_VT  = 21'h0b;
	localparam logic [20:0] C_FF  = 21'h0c;
	localparam logic [20:0] C_CR  = 21'h0d;
	localparam logic [20:0] C_SO  = 21'h0e;
	localparam logic [20:0] C_SI  = 21'h0f;
	localparam logic [20:0] C_IND = 21'h84;
	localparam logic [20:0] C_NEL = 21'h85;
	localparam logic [20:0] C_HTS = 21'h88;
	localparam logic [20:0] C_RI  = 21'h8d;
	localparam logic [20:0] GFX_LO = 21'h5F;
	localparam logic [20:0] GFX_HI = 21'h7E;

	// register indexes
	localparam logic [2:0] R_ROWS = 3'd0;
	localparam logic [2:0] R_COLS = 3'd1;
	localparam logic [2:0] R_TOP  = 3'd2;
	localparam logic [2:0] R_BOT  = 3'd3;
	localparam logic [2:0] R_AWM  = 3'd4;
	localparam logic [2:0] R_INS  = 3'd5;
	localparam logic [2:0] R_ALT  = 3'd6;
	localparam logic [2:0] R_GFX  = 3'd7;

	typedef struct packed {
		logic        action;
		logic [20:0] code;
		logic [1:0]  cell_width;
		logic [15:0] pen_style;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  row;
		logic [7:0]  col;
		logic [20:0] glyph;
		logic [15:0] style;
		logic [1:0]  count;
		logic        to_history;
		logic        wrap_pending;
		logic        last;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_WRAP1, S_CLAMP, S_WRAP2, S_INSERT, S_WRITE,
		S_CONT, S_ADV, S_TAB, S_STATUS, S_HOLD
	} state_t;

	// commands from controller
	typedef struct packed {
		logic load;
		logic wrap;
		logic clamp;
		logic ins;
		logic wr;
		logic cont;
		logic adv;
		logic ctrl;
		logic tab_step;
		logic status;
	} cmd_t;

	// status to controller
	typedef struct packed {
		logic is_print;
		logic width_zero;
		logic dwrap;
		logic need_wrap2;
		logic ins_on;
		logic need_cont;
		logic is_ht;
		logic init_busy;
		logic tab_done;
		logic emit_busy;
	} sts_t;

	function automatic logic [20:0] dec_gfx(input logic [4:0] i);
		case (i)
			5'd0: dec_gfx = 21'h00A0; 5'd1: dec_gfx = 21'h25C6;
			5'd2: dec_gfx = 21'h2592; 5'd3: dec_gfx = 21'h2409;
			5'd4: dec_gfx = 21'h240C; 5'd5: dec_gfx = 21'h240D;
			5'd6: dec_gfx = 21'h240A; 5'd7: dec_gfx = 21'h00B0;
			5'd8: dec_gfx = 21'h00B1; 5'd9: dec_gfx = 21'h2424;
			5'd10: dec_gfx = 21'h240B; 5'd11: dec_gfx = 21'h2518;
			5'd12: dec_gfx = 21'h2510; 5'd13: dec_gfx = 21'h250C;
			5'd14: dec_gfx = 21'h2514; 5'd15: dec_gfx = 21'h253C;
			5'd16: dec_gfx = 21'h23BA; 5'd17: dec_gfx = 21'h23BB;
			5'd18: dec_gfx = 21'h2500; 5'd19: dec_gfx = 21'h23BC;
			5'd20: dec_gfx = 21'h23BD; 5'd21: dec_gfx = 21'h251C;
			5'd22: dec_gfx = 21'h2524; 5'd23: dec_gfx = 21'h2534;
			5'd24: dec_gfx = 21'h252C; 5'd25: dec_gfx = 21'h2502;
			5'd26: dec_gfx = 21'h2264; 5'd27: dec_gfx = 21'h2265;
			5'd28: dec_gfx = 21'h03C0; 5'd29: dec_gfx = 21'h2260;
			5'd30: dec_gfx = 21'h00A3; 5'd31: dec_gfx = 21'h00B7;
			default: dec_gfx = 21'h0;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: src/tce_ctrl.sv
`default_nettype none
module tce_ctrl import tce_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state; emitting states wait while the output slot is full
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid && !sts.init_busy) state_d = S_DISPATCH;
			S_DISPATCH: begin
				if (!sts.is_print) state_d = sts.is_ht ? S_TAB : S_HOLD;
				else if (sts.width_zero) state_d = S_STATUS;
				else if (sts.dwrap) state_d = S_WRAP1;
				else state_d = S_CLAMP;
			end
			S_HOLD: if (!sts.emit_busy) state_d = S_STATUS;
			S_WRAP1: if (!sts.emit_busy) state_d = S_CLAMP;
			S_CLAMP: begin
				if (sts.need_wrap2) state_d = S_WRAP2;
				else if (sts.ins_on) state_d = S_INSERT;
				else state_d = S_WRITE;
			end
			S_WRAP2: if (!sts.emit_busy) state_d = sts.ins_on ? S_INSERT : S_WRITE;
			S_INSERT: if (!sts.emit_busy) state_d = S_WRITE;
			S_WRITE: if (!sts.emit_busy) state_d = sts.need_cont ? S_CONT : S_ADV;
			S_CONT: if (!sts.emit_busy) state_d = S_ADV;
			S_ADV: state_d = S_STATUS;
			S_TAB: if (sts.tab_done) state_d = S_STATUS;
			S_STATUS: if (!sts.emit_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		in_stall = (state_q != S_IDLE) || sts.init_busy;
		case (state_q)
			S_IDLE: cmd.load = in_valid && !sts.init_busy;
			S_DISPATCH: cmd.tab_step = 1'b0;
			S_HOLD: cmd.ctrl = !sts.emit_busy;
			S_WRAP1: cmd.wrap = !sts.emit_busy;
			S_CLAMP: cmd.clamp = 1'b1;
			S_WRAP2: cmd.wrap = !sts.emit_busy;
			S_INSERT: cmd.ins = !sts.emit_busy;
			S_WRITE: cmd.wr = !sts.emit_busy;
			S_CONT: cmd.cont = !sts.emit_busy;
			S_ADV: cmd.adv = 1'b1;
			S_TAB: cmd.tab_step = 1'b1;
			S_STATUS: cmd.status = !sts.emit_busy;
			default: cmd = '0;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_DISPATCH) else $error("load not dispatched");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.status |=> state_q == S_IDLE) else $error("status not final");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wrap, cmd.ins, cmd.wr, cmd.cont, cmd.status, cmd.ctrl}))
		else $error("two emits at once");

endmodule
`default_nettype wire

// File: src/tce_dp.sv
`default_nettype none
module tce_dp import tce_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_item,
	input  wire logic      cfg_valid,
	input  wire logic [2:0] cfg_index,
	input  wire logic [8:0] cfg_data,
	input  wire cmd_t      cmd,
	output sts_t           sts,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_item
);

	logic [6:0] rows_q;
	logic [8:0] cols_q;
	logic [5:0] top_q, bot_q;
	logic awm_q, ins_q, alt_q;
	logic [1:0] gfx_q;
	logic [ROW_W-1:0] crow_q;
	logic [COL_W-1:0] ccol_q;
	logic dwrap_q, aset_q;
	logic tab_mem [MAX_COLS];
	logic tab_rd_q;
	logic init_q;
	logic [COL_W-1:0] init_col_q;
	in_item_t it_q;
	logic [1:0] w_q;
	logic [COL_W:0] tcol_q;
	logic ov_q;
	out_item_t ob_q;

	// effective geometry
	logic [7:0] erows;
	logic [8:0] ecols;
	logic [5:0] ebot;
	always_comb begin
		erows = (rows_q == 7'd0) ? 8'd1 :
			(rows_q > 7'(MAX_ROWS)) ? 8'(MAX_ROWS) : {1'b0, rows_q};
		ecols = (cols_q == 9'd0) ? 9'd1 :
			(cols_q > 9'(MAX_COLS)) ? 9'(MAX_COLS) : cols_q;
		ebot = ({2'b0, bot_q} > erows - 8'd1) ? 6'(erows - 8'd1) : bot_q;
	end

	// line feed effect
	logic lf_scroll, lf_inc, scroll_ok, hist;
	always_comb begin
		scroll_ok = top_q < ebot;
		lf_scroll = (crow_q == ebot) && scroll_ok;
		lf_inc = (crow_q != ebot) && ({2'b0, crow_q} < erows - 8'd1);
		hist = (top_q == 6'd0) && ({2'b0, ebot} == erows - 8'd1) && !alt_q;
	end

	// glyph translation
	logic [20:0] glyph;
	logic gset;
	always_comb begin
		gset = aset_q ? gfx_q[1] : gfx_q[0];
		glyph = it_q.code;
		if (gset && it_q.code >= GFX_LO && it_q.code <= GFX_HI)
			glyph = dec_gfx(5'(it_q.code - GFX_LO));
	end

	logic [8:0] room;
	logic [9:0] endcol;
	assign room = ecols - {1'b0, ccol_q};
	assign endcol = {2'b0, ccol_q} + {8'b0, w_q};

	logic is_ctl, emit;
	assign is_ctl = it_q.action;
	assign emit = cmd.wrap || cmd.ins || cmd.wr || cmd.cont || cmd.status || cmd.ctrl;

	// wrap: mark row then line feed, maybe with a scroll beat queued
	logic sc_pend_q;

	// status to controller; column past the edge counts as the last column
	always_comb begin
		sts.is_print = !it_q.action;
		sts.width_zero = (it_q.cell_width == 2'd0);
		sts.dwrap = dwrap_q;
		sts.need_wrap2 = (w_q == 2'd2) && ({1'b0, ccol_q} >= ecols - 9'd1) && awm_q;
		sts.ins_on = ins_q;
		sts.need_cont = (w_q == 2'd2) && ({1'b0, ccol_q} + 9'd1 < ecols);
		sts.is_ht = is_ctl && (it_q.code == C_HT);
		sts.init_busy = init_q;
		sts.tab_done = (tcol_q >= ecols) || tab_rd_q;
		sts.emit_busy = (ov_q && out_stall) || sc_pend_q;
	end

	// next output beat
	out_item_t nb;
	always_comb begin
		nb = '0;
		if (cmd.wrap || (cmd.ctrl && lf_scroll)) begin
			nb.kind = K_WRAP;
			nb.row = crow_q;
		end
		if (cmd.ins) begin
			nb.kind = K_INSERT; nb.row = crow_q; nb.col = ccol_q;
			nb.style = it_q.pen_style;
			nb.count = ({7'b0, w_q} < room) ? w_q : room[1:0];
		end
		if (cmd.wr) begin
			nb.kind = K_WRITE; nb.row = crow_q; nb.col = ccol_q; nb.glyph = glyph;
			nb.style = it_q.pen_style; nb.count = w_q;
		end
		if (cmd.cont) begin
			nb.kind = K_CONT; nb.row = crow_q; nb.col = ccol_q + 8'd1;
			nb.style = it_q.pen_style;
		end
		if (cmd.status) begin
			nb.kind = K_STATUS; nb.row = crow_q; nb.col = ccol_q;
			nb.wrap_pending = dwrap_q; nb.last = 1'b1;
		end
	end

	// control byte classification
	logic c_lf, c_ri, c_bel;
	always_comb begin
		c_lf = (it_q.code == C_LF) || (it_q.code == C_VT) || (it_q.code == C_FF) ||
			(it_q.code == C_IND) || (it_q.code == C_NEL);
		c_ri = it_q.code == C_RI;
		c_bel = it_q.code == C_BEL;
	end

	// a control beat, if any, from the hold state
	out_item_t cb;
	logic cb_v;
	always_comb begin
		cb = '0;
		cb_v = 1'b0;
		if (c_bel) begin
			cb.kind = K_BELL; cb_v = 1'b1;
		end else if (c_lf && lf_scroll) begin
			cb.kind = K_SCRUP; cb.row = top_q; cb.style = it_q.pen_style;
			cb.count = 2'd1; cb.to_history = hist; cb_v = 1'b1;
		end else if (c_ri && crow_q == top_q && scroll_ok) begin
			cb.kind = K_SCRDN; cb.row = top_q; cb.style = it_q.pen_style;
			cb.count = 2'd1; cb_v = 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sc_pend_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			if (cmd.ctrl && cb_v) ov_q <= 1'b1;
			if (cmd.wrap) begin
				ov_q <= ({1'b0, crow_q} < erows[6:0]) || lf_scroll;
				sc_pend_q <= ({1'b0, crow_q} < erows[6:0]) && lf_scroll;
			end
			if (sc_pend_q && !(ov_q && out_stall)) begin
				ov_q <= 1'b1;
				sc_pend_q <= 1'b0;
			end
			if (cmd.ins || cmd.wr || cmd.cont || cmd.status) ov_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ctrl) ob_q <= cb;
		else if (cmd.wrap) begin
			if ({1'b0, crow_q} < erows[6:0]) ob_q <= nb;
			else ob_q <= '{kind: K_SCRUP, row: top_q, col: 8'd0, glyph: 21'd0,
				style: it_q.pen_style, count: 2'd1, to_history: hist,
				wrap_pending: 1'b0, last: 1'b0};
		end else if (sc_pend_q && !(ov_q && out_stall))
			ob_q <= '{kind: K_SCRUP, row: top_q, col: 8'd0, glyph: 21'd0,
				style: it_q.pen_style, count: 2'd1, to_history: hist,
				wrap_pending: 1'b0, last: 1'b0};
		else if (emit) ob_q <= nb;
	end

	// hold the scroll beat of a wrap until its slot frees
	assign out_valid = ov_q;
	assign out_item = ob_q;

	// tab stop loading pass after reset, one column a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b1;
			init_col_q <= '0;
		end else if (init_q) begin
			init_col_q <= init_col_q + 8'd1;
			if (init_col_q == 8'(MAX_COLS - 1)) init_q <= 1'b0;
		end
	end

	// tab stop memory; the read runs one column ahead of the search
	always_ff @(posedge clk) begin
		if (init_q) tab_mem[init_col_q] <= (init_col_q[2:0] == 3'd0);
		else if (cmd.ctrl && it_q.code == C_HTS && {1'b0, ccol_q} < ecols)
			tab_mem[ccol_q] <= 1'b1;
		if (cmd.load) tab_rd_q <= tab_mem[ccol_q + 8'd1];
		else if (cmd.tab_step && !sts.tab_done) tab_rd_q <= tab_mem[tcol_q[7:0] + 8'd1];
	end

	// configuration and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd24; cols_q <= 9'd80; top_q <= '0; bot_q <= 6'd23;
			awm_q <= 1'b1; ins_q <= 1'b0; alt_q <= 1'b0; gfx_q <= '0;
			crow_q <= '0; ccol_q <= '0; dwrap_q <= 1'b0; aset_q <= 1'b0;
			tcol_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					R_ROWS: rows_q <= cfg_data[6:0];
					R_COLS: cols_q <= cfg_data;
					R_TOP:  top_q <= cfg_data[5:0];
					R_BOT:  bot_q <= cfg_data[5:0];
					R_AWM:  awm_q <= cfg_data[0];
					R_INS:  ins_q <= cfg_data[0];
					R_ALT:  alt_q <= cfg_data[0];
					R_GFX:  gfx_q <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (cmd.load) tcol_q <= {1'b0, ccol_q} + 9'd1;
			if (cmd.wrap) begin
				ccol_q <= '0;
				dwrap_q <= 1'b0;
				if (lf_inc) crow_q <= crow_q + 6'd1;
			end
			if (cmd.clamp) begin
				if ({2'b0, crow_q} >= erows) crow_q <= 6'(erows - 8'd1);
				if ({1'b0, ccol_q} >= ecols) ccol_q <= 8'(ecols - 9'd1);
			end
			if (cmd.adv) begin
				if (endcol >= {1'b0, ecols}) begin
					ccol_q <= 8'(ecols - 9'd1);
					if (awm_q) dwrap_q <= 1'b1;
				end else ccol_q <= endcol[7:0];
			end
			if (cmd.tab_step) begin
				if ({1'b0, ccol_q} >= ecols - 9'd1) begin
					tcol_q <= 9'h100;
				end else if (sts.tab_done) begin
					ccol_q <= (tcol_q >= ecols) ? 8'(ecols - 9'd1) : tcol_q[7:0];
					dwrap_q <= 1'b0;
				end else tcol_q <= tcol_q + 9'd1;
			end
			if (cmd.ctrl) begin
				case (it_q.code)
					C_BS: begin
						if (ccol_q != '0) ccol_q <= ccol_q - 8'd1;
						dwrap_q <= 1'b0;
					end
					C_SO: aset_q <= 1'b1;
					C_SI: aset_q <= 1'b0;
					C_LF, C_VT, C_FF, C_IND: if (lf_inc) crow_q <= crow_q + 6'd1;
					C_CR: begin ccol_q <= '0; dwrap_q <= 1'b0; end
					C_NEL: begin
						if (lf_inc) crow_q <= crow_q + 6'd1;
						ccol_q <= '0; dwrap_q <= 1'b0;
					end
					// tab stop set in the memory block
					C_HTS: ;
					C_RI: if (crow_q != top_q && crow_q != '0) crow_q <= crow_q - 6'd1;
					default: ;
				endcase
			end
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q <= in_item;
			w_q <= (in_item.cell_width == 2'd3) ? 2'd2 : in_item.cell_width;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> ov_q) else $error("beat lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.adv |=> {1'b0, ccol_q} < ecols) else $error("cursor past edge");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> $stable(ob_q)) else $error("beat changed");

endmodule
`default_nettype wire

// File: src/terminal_cursor_engine_core.sv
// a print item steps through dispatch, clamp and cursor update and emits a beat
// for each wrap, insert, write, continuation cell and status; a wrap that scrolls
// adds a scroll beat; controls pass dispatch, hold and status; horizontal tab
// steps one column a cycle; output stalls hold the emitting steps; one item at a
// time; reset: arst_n clears cursor, wrap flag, charset and loads registers; then a
// pass loads the tab stop of every column while the input is stalled
`default_nettype none
module terminal_cursor_engine_core import tce_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [8:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tce_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	tce_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cfg_valid(cfg_valid),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_data)
	);

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
`default_nettype none

// expected grid commands per terminal input, checked in order
class grid_scoreboard;
	bit [6:0] rows_reg;
	bit [8:0] cols_reg;
	bit [5:0] top_reg, bot_reg;
	bit awm, ins, alt;
	bit [1:0] gfx;
	int unsigned crow, ccol;
	bit dwrap, gset;
	bit stops[256];
	tce_pkg::out_item_t pending[$];
	int errors;
	bit [15:0] pen;

	function void reset_state();
		rows_reg = 24; cols_reg = 80; top_reg = 0; bot_reg = 23;
		awm = 1; ins = 0; alt = 0; gfx = 0;
		crow = 0; ccol = 0; dwrap = 0; gset = 0;
		for (int i = 0; i < 256; i++) stops[i] = (i % 8 == 0);
	endfunction

	function void set_reg(bit [2:0] idx, bit [8:0] val);
		case (idx)
			tce_pkg::R_ROWS: rows_reg = val[6:0];
			tce_pkg::R_COLS: cols_reg = val;
			tce_pkg::R_TOP:  top_reg = val[5:0];
			tce_pkg::R_BOT:  bot_reg = val[5:0];
			tce_pkg::R_AWM:  awm = val[0];
			tce_pkg::R_INS:  ins = val[0];
			tce_pkg::R_ALT:  alt = val[0];
			tce_pkg::R_GFX:  gfx = val[1:0];
			default: ;
		endcase
	endfunction

	function int unsigned n_rows();
		return rows_reg < 1 ? 1 : (rows_reg > 64 ? 64 : rows_reg);
	endfunction

	function int unsigned n_cols();
		return cols_reg < 1 ? 1 : (cols_reg > 256 ? 256 : cols_reg);
	endfunction

	function int unsigned bottom_row();
		return bot_reg > n_rows() - 1 ? n_rows() - 1 : bot_reg;
	endfunction

	function void push(bit [2:0] k, int unsigned r, int unsigned c, int unsigned g,
			int unsigned s, int unsigned n, bit h);
		tce_pkg::out_item_t o;
		o = '0;
		o.kind = k; o.row = r[5:0]; o.col = c[7:0]; o.glyph = g[20:0];
		o.style = s[15:0]; o.count = n[1:0]; o.to_history = h;
		pending.push_back(o);
	endfunction

	function void feed_line();
		if (crow == bottom_row()) begin
			if (top_reg < bottom_row())
				push(tce_pkg::K_SCRUP, top_reg, 0, 0, pen, 1,
					top_reg == 0 && bottom_row() == n_rows() - 1 && !alt);
		end else if (crow < n_rows() - 1) begin
			crow++;
		end
	endfunction

	function void wrap_now();
		if (crow < n_rows()) push(tce_pkg::K_WRAP, crow, 0, 0, 0, 0, 0);
		ccol = 0;
		feed_line();
	endfunction

	function void put_cell(bit [20:0] code, bit [1:0] w_in);
		int unsigned w, room;
		bit [20:0] g;
		bit [20:0] table_gfx[32];
		table_gfx = '{21'h00A0, 21'h25C6, 21'h2592, 21'h2409, 21'h240C, 21'h240D,
			21'h240A, 21'h00B0, 21'h00B1, 21'h2424, 21'h240B, 21'h2518, 21'h2510,
			21'h250C, 21'h2514, 21'h253C, 21'h23BA, 21'h23BB, 21'h2500, 21'h23BC,
			21'h23BD, 21'h251C, 21'h2524, 21'h2534, 21'h252C, 21'h2502, 21'h2264,
			21'h2265, 21'h03C0, 21'h2260, 21'h00A3, 21'h00B7};
		if (w_in == 0) return;
		w = w_in > 2 ? 2 : w_in;
		g = code;
		if (gfx[gset] && code >= tce_pkg::GFX_LO && code <= tce_pkg::GFX_HI)
			g = table_gfx[code - tce_pkg::GFX_LO];
		if (dwrap) begin
			wrap_now();
			dwrap = 0;
		end
		if (crow >= n_rows()) crow = n_rows() - 1;
		if (ccol >= n_cols()) ccol = n_cols() - 1;
		if (w == 2 && ccol == n_cols() - 1 && awm) wrap_now();
		if (ins) begin
			room = n_cols() - ccol;
			push(tce_pkg::K_INSERT, crow, ccol, 0, pen, w < room ? w : room, 0);
		end
		push(tce_pkg::K_WRITE, crow, ccol, g, pen, w, 0);
		if (w == 2 && ccol + 1 < n_cols()) push(tce_pkg::K_CONT, crow, ccol + 1, 0, pen, 0, 0);
		if (ccol + w >= n_cols()) begin
			ccol = n_cols() - 1;
			if (awm) dwrap = 1;
		end else begin
			ccol += w;
		end
	endfunction

	function void take_control(bit [20:0] b);
		int unsigned c;
		case (b)
			tce_pkg::C_BEL: push(tce_pkg::K_BELL, 0, 0, 0, 0, 0, 0);
			tce_pkg::C_BS: begin
				if (ccol > 0) ccol--;
				dwrap = 0;
			end
			tce_pkg::C_HT: begin
				if (ccol < n_cols() - 1) begin
					c = ccol + 1;
					while (c < n_cols() && !stops[c]) c++;
					if (c >= n_cols()) c = n_cols() - 1;
					ccol = c;
					dwrap = 0;
				end
			end
			tce_pkg::C_SO: gset = 1;
			tce_pkg::C_SI: gset = 0;
			tce_pkg::C_LF, tce_pkg::C_VT, tce_pkg::C_FF, tce_pkg::C_IND: feed_line();
			tce_pkg::C_CR: begin
				ccol = 0;
				dwrap = 0;
			end
			tce_pkg::C_NEL: begin
				feed_line();
				ccol = 0;
				dwrap = 0;
			end
			tce_pkg::C_HTS: if (ccol < n_cols()) stops[ccol] = 1;
			tce_pkg::C_RI: begin
				if (crow == top_reg) begin
					if (top_reg < bottom_row())
						push(tce_pkg::K_SCRDN, top_reg, 0, 0, pen, 1, 0);
				end else if (crow > 0) begin
					crow--;
				end
			end
			default: ;
		endcase
	endfunction

	// note an accepted input beat and queue its expected results
	function void note_input(tce_pkg::in_item_t it);
		tce_pkg::out_item_t st;
		pen = it.pen_style;
		if (!it.action) put_cell(it.code, it.cell_width);
		else take_control(it.code);
		st = '0;
		st.kind = tce_pkg::K_STATUS; st.row = crow[5:0]; st.col = ccol[7:0];
		st.wrap_pending = dwrap; st.last = 1;
		pending.push_back(st);
	endfunction

	function void report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endfunction

	// compare one result beat against the oldest expectation
	function void check_result(tce_pkg::out_item_t got);
		tce_pkg::out_item_t e;
		if (pending.size() == 0) begin
			report($sformatf("unexpected beat %h", got));
			return;
		end
		e = pending.pop_front();
		if (got.kind != e.kind) report($sformatf("kind %0d exp %0d", got.kind, e.kind));
		if (got.row != e.row) report($sformatf("row %0d exp %0d", got.row, e.row));
		if (got.col != e.col) report($sformatf("col %0d exp %0d", got.col, e.col));
		if (got.glyph != e.glyph) report($sformatf("glyph %h exp %h", got.glyph, e.glyph));
		if (got.style != e.style) report($sformatf("style %h exp %h", got.style, e.style));
		if (got.count != e.count) report($sformatf("count %0d exp %0d", got.count, e.count));
		if (got.to_history != e.to_history) report("to_history differs");
		if (got.wrap_pending != e.wrap_pending) report("wrap_pending differs");
		if (got.last != e.last) report("last differs");
	endfunction
endclass

module testbench;
	import tce_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_item_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [8:0] cfg_data = '0;
	grid_scoreboard sb;
	int cycles = 0;

	terminal_cursor_engine_core u_dut (.*);

	always #2 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: check beats, random stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	initial begin
		int gap;
		@(negedge clk);
		while (1) begin
			gap = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0) gap = 0;
			out_stall = gap != 0;
			repeat (gap) @(negedge clk);
			out_stall = 0;
			@(negedge clk);
		end
	end

	task automatic send_item(in_item_t it);
		repeat ($urandom_range(0, 5)) @(negedge clk);
		in_valid = 1;
		in_data = it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(it);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic write_reg(bit [2:0] idx, int unsigned val);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val[8:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val[8:0]);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	function automatic in_item_t make_print(int unsigned c, int unsigned w);
		in_item_t it;
		it.action = 0; it.code = c[20:0]; it.cell_width = w[1:0];
		it.pen_style = 16'($urandom);
		return it;
	endfunction

	function automatic in_item_t make_ctrl(int unsigned c);
		in_item_t it;
		it.action = 1; it.code = c[20:0]; it.cell_width = 2'($urandom);
		it.pen_style = 16'($urandom);
		return it;
	endfunction

	function automatic in_item_t random_item();
		bit [20:0] ctl[13];
		int unsigned r;
		ctl = '{C_BEL, C_BS, C_HT, C_LF, C_VT, C_FF, C_CR, C_SO, C_SI, C_IND, C_NEL,
			C_HTS, C_RI};
		r = $urandom_range(0, 99);
		if (r < 55) return make_print($urandom_range(32, 126), $urandom_range(1, 2));
		if (r < 62) return make_print($urandom & 21'h1FFFFF, $urandom);
		if (r < 92) return make_ctrl(ctl[$urandom_range(0, 12)]);
		if (r < 96) return make_ctrl($urandom_range(0, 255));
		return make_ctrl($urandom & 21'h1FFFFF);
	endfunction

	// register settings per phase: rows, cols, top, bottom, awm, ins, alt, gfx
	task automatic apply_phase(int p);
		case (p)
			0: begin
				write_reg(R_ROWS, 64); write_reg(R_COLS, 256); write_reg(R_TOP, 0);
				write_reg(R_BOT, 63); write_reg(R_AWM, 1); write_reg(R_INS, 1);
				write_reg(R_ALT, 1); write_reg(R_GFX, 3);
			end
			1: begin
				write_reg(R_ROWS, 1); write_reg(R_COLS, 1); write_reg(R_TOP, 0);
				write_reg(R_BOT, 0); write_reg(R_AWM, 0); write_reg(R_INS, 0);
				write_reg(R_ALT, 0); write_reg(R_GFX, 1);
			end
			2: begin
				write_reg(R_ROWS, 0); write_reg(R_COLS, 0);
				write_reg(R_TOP, 63); write_reg(R_BOT, 63); write_reg(R_GFX, 2);
			end
			3: begin
				write_reg(R_ROWS, 127); write_reg(R_COLS, 511); write_reg(R_TOP, 2);
				write_reg(R_BOT, 5); write_reg(R_AWM, 1); write_reg(R_INS, 1);
			end
			default: begin
				write_reg(R_ROWS, $urandom_range(2, 8)); write_reg(R_COLS, $urandom_range(2, 20));
				write_reg(R_TOP, $urandom_range(0, 3)); write_reg(R_BOT, $urandom_range(0, 63));
				write_reg(R_AWM, $urandom); write_reg(R_INS, $urandom);
				write_reg(R_ALT, $urandom); write_reg(R_GFX, $urandom);
			end
		endcase
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: small screen to reach wraps and scrolls quickly
		write_reg(R_ROWS, 3); write_reg(R_COLS, 4); write_reg(R_BOT, 2);
		write_reg(R_GFX, 1);
		send_item(make_print(21'h5F, 1));
		send_item(make_print(21'h7E, 2));
		send_item(make_print(21'h1FFFFF, 3));
		send_item(make_print(21'h41, 2));
		send_item(make_print(21'h42, 0));
		send_item(make_print(21'h60, 1));
		send_item(make_ctrl(C_SO));
		send_item(make_print(21'h71, 1));
		send_item(make_ctrl(C_SI));
		send_item(make_ctrl(C_BEL));
		send_item(make_ctrl(C_HT));
		send_item(make_ctrl(C_HT));
		send_item(make_ctrl(C_BS));
		send_item(make_ctrl(C_HTS));
		send_item(make_ctrl(C_CR));
		send_item(make_ctrl(C_LF));
		send_item(make_ctrl(C_VT));
		send_item(make_ctrl(C_FF));
		send_item(make_ctrl(C_IND));
		send_item(make_ctrl(C_NEL));
		send_item(make_ctrl(C_RI));
		send_item(make_ctrl(C_RI));
		send_item(make_ctrl(C_RI));
		send_item(make_ctrl(21'h1FFFFF));
		send_item(make_ctrl(21'h00));
		drain();

		// random phases through several register settings
		for (int p = 0; p < 8; p++) begin
			apply_phase(p);
			for (int i = 0; i < 32; i++) send_item(random_item());
			drain();
		end
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// File: filelist.f
src/tce_pkg.sv
src/tce_ctrl.sv
src/tce_dp.sv
src/terminal_cursor_engine_core.sv
verif/testbench.sv
